FILE: hw/rtl/mlt_pkg.sv
// ----------------------------------------------------------------------------
// mlt_pkg: shared types and codes for the MAC learning table
// Field widths, request opcodes, status codes, the stored entry layout and
// the bit positions of the stream payloads.
// ----------------------------------------------------------------------------
package mlt_pkg;

  localparam int MAC_W  = 48;
  localparam int PORT_W = 6;
  localparam int OP_W   = 2;
  localparam int ST_W   = 2;

  // Input tdata: mac_key, port, zero fill to whole bytes
  localparam int IN_TDATA_W = 56;
  localparam int IN_MAC_LSB  = 0;
  localparam int IN_PORT_LSB = IN_MAC_LSB + MAC_W;

  // Output tdata: hit, out_port, status, zero fill to whole bytes
  localparam int OUT_TDATA_W   = 16;
  localparam int OUT_HIT_BIT   = 0;
  localparam int OUT_PORT_LSB  = 1;
  localparam int OUT_ST_LSB    = OUT_PORT_LSB + PORT_W;
  localparam int OUT_USED_W    = OUT_ST_LSB + ST_W;

  typedef enum logic [OP_W-1:0] {
    OP_LOOKUP = 2'd0,
    OP_LEARN  = 2'd1,
    OP_DELETE = 2'd2,
    OP_CLEAR  = 2'd3
  } opcode_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  typedef struct packed {
    logic              valid;
    logic [PORT_W-1:0] port;
    logic [MAC_W-1:0]  mac;
  } entry_t;

endpackage

FILE: hw/rtl/mac_learning_table_unit.sv
// ----------------------------------------------------------------------------
// mac_learning_table_unit: MAC address to port learning table
// Lookup, learn, delete and clear over a slot memory, scanned one slot a
// cycle through a single shared key comparator.
// ----------------------------------------------------------------------------
// A result follows the one-slot-per-cycle scan of the slot memory through
//   its single read port (a clear writes every slot instead of scanning).
// A new request is taken only after the previous result has been loaded
//   into the output register.
// Reset: synchronous, active high; a clearing pass then writes every slot
//   invalid, with s_tready low throughout.
module mac_learning_table_unit #(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic                               clk,
  input  logic                               rst,
  // request stream
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [mlt_pkg::IN_TDATA_W-1:0]     s_tdata,  // mac_key[47:0], port[53:48]
  input  logic [mlt_pkg::OP_W-1:0]           s_tuser,  // opcode[1:0]
  // result stream
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [mlt_pkg::OUT_TDATA_W-1:0]    m_tdata   // hit[0], out_port[6:1], status[8:7]
);

  localparam int AW = $clog2(TABLE_ENTRIES);
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CW-1:0] CNT_END  = CW'(TABLE_ENTRIES);
  localparam logic [CW-1:0] CNT_LAST = CW'(TABLE_ENTRIES - 1);

  // Sequencer states, one-hot
  typedef enum logic [4:0] {
    S_INIT  = 5'b00001,  // clearing pass after reset
    S_IDLE  = 5'b00010,  // wait for a request
    S_SCAN  = 5'b00100,  // read and compare every slot
    S_CLEAR = 5'b01000,  // invalidate every slot
    S_WRITE = 5'b10000   // write back and post the result
  } state_t;

  state_t state, state_next;
  logic [CW-1:0] cnt, cnt_next;

  // Request held for the whole operation
  mlt_pkg::opcode_t          req_op;
  logic [mlt_pkg::MAC_W-1:0]  req_mac;
  logic [mlt_pkg::PORT_W-1:0] req_port;

  // Slot memory: one write port, one registered read port
  mlt_pkg::entry_t slot_mem [TABLE_ENTRIES];
  mlt_pkg::entry_t rd_data;
  logic            mem_re, mem_we;
  logic [AW-1:0]   mem_raddr, mem_waddr;
  mlt_pkg::entry_t mem_wdata;

  // Compare stage tracking the slot whose data sits in rd_data
  logic          cmp_vld;
  logic [AW-1:0] cmp_idx;
  logic          key_match;

  // Scan results
  logic                       found;
  logic [AW-1:0]              found_idx;
  logic [mlt_pkg::PORT_W-1:0] found_port;
  logic                       free_ok;
  logic [AW-1:0]              free_idx;

  // Output register
  logic                       out_valid;
  logic                       out_hit;
  logic [mlt_pkg::PORT_W-1:0] out_port;
  mlt_pkg::status_t           out_status;

  logic                       load_out;
  logic                       res_hit;
  logic [mlt_pkg::PORT_W-1:0] res_port;
  mlt_pkg::status_t           res_status;

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = out_valid;
  assign m_tdata  = {{(mlt_pkg::OUT_TDATA_W - mlt_pkg::OUT_USED_W){1'b0}},
                     out_status, out_port, out_hit};

  // The one shared comparator: stored key against the request key
  assign key_match = rd_data.valid && (rd_data.mac == req_mac);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= slot_mem[mem_raddr];
    end
  end

  // Sequencer and memory port control
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    mem_re     = 1'b0;
    mem_raddr  = cnt[AW-1:0];
    mem_we     = 1'b0;
    mem_waddr  = cnt[AW-1:0];
    mem_wdata  = '{valid: 1'b0, port: req_port, mac: req_mac};
    load_out   = 1'b0;
    res_hit    = 1'b0;
    res_port   = '0;
    res_status = mlt_pkg::ST_OK;

    case (state)
      S_INIT: begin
        // invalidate slot cnt; leave for idle after the last one
        mem_we = 1'b1;
        if (cnt == CNT_LAST) begin
          state_next = S_IDLE;
          cnt_next   = '0;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_IDLE: begin
        if (s_tvalid) begin
          cnt_next   = '0;
          state_next = (mlt_pkg::opcode_t'(s_tuser) == mlt_pkg::OP_CLEAR) ? S_CLEAR : S_SCAN;
        end
      end
      S_SCAN: begin
        // issue one read per cycle; finish once the last slot is compared
        if (cnt != CNT_END) begin
          mem_re   = 1'b1;
          cnt_next = cnt + 1'b1;
        end else if (cmp_vld) begin
          state_next = S_WRITE;
        end
      end
      S_CLEAR: begin
        mem_we = 1'b1;
        if (cnt == CNT_LAST) begin
          state_next = S_WRITE;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_WRITE: begin
        case (req_op)
          mlt_pkg::OP_LOOKUP: begin
            res_hit    = found;
            res_port   = found ? found_port : '0;
            res_status = found ? mlt_pkg::ST_OK : mlt_pkg::ST_NOT_FOUND;
          end
          mlt_pkg::OP_LEARN: begin
            res_hit    = found;
            res_status = (found || free_ok) ? mlt_pkg::ST_OK : mlt_pkg::ST_FULL;
          end
          mlt_pkg::OP_DELETE: begin
            res_hit    = found;
            res_status = found ? mlt_pkg::ST_OK : mlt_pkg::ST_NOT_FOUND;
          end
          default: begin
            res_hit    = 1'b0;
            res_status = mlt_pkg::ST_OK;
          end
        endcase
        // hold until the output register is free, then write back once
        if (!out_valid || m_tready) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
          mem_waddr  = found ? found_idx : free_idx;
          mem_wdata.valid = (req_op == mlt_pkg::OP_LEARN);
          case (req_op)
            mlt_pkg::OP_LEARN:  mem_we = found || free_ok;
            mlt_pkg::OP_DELETE: mem_we = found;
            default:            mem_we = 1'b0;
          endcase
        end
      end
      default: begin
        state_next = S_INIT;
        cnt_next   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_INIT;
      cnt     <= '0;
      cmp_vld <= 1'b0;
    end else begin
      state   <= state_next;
      cnt     <= cnt_next;
      cmp_vld <= mem_re;
    end
  end

  // Capture the request and track the scan results
  always_ff @(posedge clk) begin
    cmp_idx <= mem_raddr;
    if (s_tvalid && s_tready) begin
      req_op   <= mlt_pkg::opcode_t'(s_tuser);
      req_mac  <= s_tdata[mlt_pkg::IN_MAC_LSB +: mlt_pkg::MAC_W];
      req_port <= s_tdata[mlt_pkg::IN_PORT_LSB +: mlt_pkg::PORT_W];
      found    <= 1'b0;
      free_ok  <= 1'b0;
    end else if (cmp_vld) begin
      if (key_match && !found) begin
        found      <= 1'b1;
        found_idx  <= cmp_idx;
        found_port <= rd_data.port;
      end
      // keep the lowest free slot for an insert
      if (!rd_data.valid && !free_ok) begin
        free_ok  <= 1'b1;
        free_idx <= cmp_idx;
      end
    end
  end

  // Output register: a new result may load in the cycle the old one leaves
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_hit    <= res_hit;
      out_port   <= res_port;
      out_status <= res_status;
    end
  end

endmodule

FILE: hw/rtl/mlt_checker.sv
// ----------------------------------------------------------------------------
// mlt_checker: port-level checks for the MAC learning table
// Watches the request and result streams and flags results or handshakes
// that the table can never produce.
// ----------------------------------------------------------------------------
module mlt_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [mlt_pkg::OUT_TDATA_W-1:0] m_tdata
);

  logic                       hit;
  logic [mlt_pkg::PORT_W-1:0] oport;
  logic [mlt_pkg::ST_W-1:0]   status;

  assign hit    = m_tdata[mlt_pkg::OUT_HIT_BIT];
  assign oport  = m_tdata[mlt_pkg::OUT_PORT_LSB +: mlt_pkg::PORT_W];
  assign status = m_tdata[mlt_pkg::OUT_ST_LSB +: mlt_pkg::ST_W];

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // one request at a time: busy right after a transaction
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request accepted while busy");

  // a hit always reports ok
  a_hit_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && hit |-> status == mlt_pkg::ST_OK)
    else $error("hit with a failing status");

  // a port is reported only with a hit
  a_port_needs_hit: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (oport != '0) |-> hit && status == mlt_pkg::ST_OK)
    else $error("port reported without a hit");

  // no status code beyond table full
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> status == mlt_pkg::ST_OK || status == mlt_pkg::ST_NOT_FOUND ||
                 status == mlt_pkg::ST_FULL)
    else $error("undefined status code");

endmodule

bind mac_learning_table_unit mlt_checker u_mlt_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

FILE: test/tb_mac_learning_table_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mac_learning_table_unit: self-checking bench for the MAC learning table
// Drives lookup, learn, delete and clear requests over the request stream
// with bursty traffic, and stalls the result stream on its own random
// pattern. A shadow table beside the bench predicts hit, port and status.
// Each result is checked against the oldest pending prediction.
// ----------------------------------------------------------------------------
module tb_mac_learning_table_unit;

  localparam int TABLE_ENTRIES = 64;
  localparam int POOL_SIZE     = 80;
  // Cycles without any transaction before the run is declared hung. Take the
  // time one request takes, add the longest sender gap and the longest
  // receiver stall, then take that many times over.
  localparam int IDLE_LIMIT    = 4000;

  typedef struct {
    logic                       hit;
    logic [mlt_pkg::PORT_W-1:0] port;
    mlt_pkg::status_t           status;
  } response_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            s_tvalid = 1'b0;
  logic                            s_tready;
  logic [mlt_pkg::IN_TDATA_W-1:0]  s_tdata = '0;  // mac_key[47:0], port[53:48]
  logic [mlt_pkg::OP_W-1:0]        s_tuser = '0;  // opcode[1:0]
  logic                            m_tvalid;
  logic                            m_tready = 1'b0;
  logic [mlt_pkg::OUT_TDATA_W-1:0] m_tdata;       // hit[0], out_port[6:1], status[8:7]

  // Shadow copy of the table contents
  logic                       shadow_valid [TABLE_ENTRIES];
  logic [mlt_pkg::MAC_W-1:0]  shadow_mac   [TABLE_ENTRIES];
  logic [mlt_pkg::PORT_W-1:0] shadow_port  [TABLE_ENTRIES];

  response_t                 pending_responses[$];
  logic [mlt_pkg::MAC_W-1:0] mac_pool[POOL_SIZE];
  int                        error_count = 0;
  int                        burst_left = 0;
  int                        idle_cycles = 0;

  mac_learning_table_unit #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Shadow table: apply one request and return the response it should give
  // --------------------------------------------------------------------------
  function automatic response_t predict_response(
      input mlt_pkg::opcode_t           op,
      input logic [mlt_pkg::MAC_W-1:0]  mac,
      input logic [mlt_pkg::PORT_W-1:0] prt);
    response_t rsp;
    int        match_idx;
    int        free_idx;
    rsp.hit    = 1'b0;
    rsp.port   = '0;
    rsp.status = mlt_pkg::ST_OK;
    match_idx  = -1;
    free_idx   = -1;
    // Find the matching slot and the lowest free slot in one pass
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (shadow_valid[i] && shadow_mac[i] == mac && match_idx < 0) match_idx = i;
      if (!shadow_valid[i] && free_idx < 0) free_idx = i;
    end
    case (op)
      mlt_pkg::OP_LOOKUP: begin
        if (match_idx >= 0) begin
          rsp.hit  = 1'b1;
          rsp.port = shadow_port[match_idx];
        end else begin
          rsp.status = mlt_pkg::ST_NOT_FOUND;
        end
      end
      mlt_pkg::OP_LEARN: begin
        if (match_idx >= 0) begin
          // Known address: overwrite the port only
          rsp.hit = 1'b1;
          shadow_port[match_idx] = prt;
        end else if (free_idx >= 0) begin
          shadow_valid[free_idx] = 1'b1;
          shadow_mac[free_idx]   = mac;
          shadow_port[free_idx]  = prt;
        end else begin
          // Full table: refuse, leave contents alone
          rsp.status = mlt_pkg::ST_FULL;
        end
      end
      mlt_pkg::OP_DELETE: begin
        if (match_idx >= 0) begin
          rsp.hit = 1'b1;
          shadow_valid[match_idx] = 1'b0;
        end else begin
          rsp.status = mlt_pkg::ST_NOT_FOUND;
        end
      end
      default: begin
        for (int i = 0; i < TABLE_ENTRIES; i++) shadow_valid[i] = 1'b0;
      end
    endcase
    return rsp;
  endfunction

  function automatic logic [mlt_pkg::MAC_W-1:0] rand_mac();
    logic [63:0] wide;
    wide = {$urandom, $urandom};
    return wide[mlt_pkg::MAC_W-1:0];
  endfunction

  // --------------------------------------------------------------------------
  // Send one request. Traffic comes in bursts; between bursts drop tvalid
  // for a random gap. Data changes on the falling edge, acceptance is seen
  // on the rising edge, and the prediction is queued at that edge.
  // --------------------------------------------------------------------------
  task automatic send_request(input mlt_pkg::opcode_t           op,
                              input logic [mlt_pkg::MAC_W-1:0]  mac,
                              input logic [mlt_pkg::PORT_W-1:0] prt);
    @(negedge clk);
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 30)) @(negedge clk);
      burst_left = $urandom_range(1, 8);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {{(mlt_pkg::IN_TDATA_W - mlt_pkg::MAC_W - mlt_pkg::PORT_W){1'b0}},
                 prt, mac};
    burst_left--;
    do @(posedge clk); while (s_tready !== 1'b1);
    pending_responses.push_back(predict_response(op, mac, prt));
  endtask

  // Non-learn requests carry a random port that the block must ignore
  task automatic send_keyed(input mlt_pkg::opcode_t          op,
                            input logic [mlt_pkg::MAC_W-1:0] mac);
    send_request(op, mac, mlt_pkg::PORT_W'($urandom_range(0, 63)));
  endtask

  // --------------------------------------------------------------------------
  // Result checker: compare every result transaction with the oldest
  // pending prediction
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    response_t                  want;
    logic                       got_hit;
    logic [mlt_pkg::PORT_W-1:0] got_port;
    logic [mlt_pkg::ST_W-1:0]   got_status;
    if (!rst && m_tvalid && m_tready) begin
      got_hit    = m_tdata[mlt_pkg::OUT_HIT_BIT];
      got_port   = m_tdata[mlt_pkg::OUT_PORT_LSB +: mlt_pkg::PORT_W];
      got_status = m_tdata[mlt_pkg::OUT_ST_LSB +: mlt_pkg::ST_W];
      if (pending_responses.size() == 0) begin
        $error("unexpected result: hit %0d, out_port %0d, status %0d",
               got_hit, got_port, got_status);
        error_count++;
      end else begin
        want = pending_responses.pop_front();
        if (got_hit !== want.hit) begin
          $error("hit mismatch: expected %0d, actual %0d", want.hit, got_hit);
          error_count++;
        end
        if (got_port !== want.port) begin
          $error("out_port mismatch: expected %0d, actual %0d", want.port, got_port);
          error_count++;
        end
        if (got_status !== want.status) begin
          $error("status mismatch: expected %0d, actual %0d", want.status, got_status);
          error_count++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver back-pressure: hold m_tready at one level for a random stretch,
  // mostly ready, with short stalls and now and then a long ready run
  // --------------------------------------------------------------------------
  int  ready_hold = 0;
  logic ready_level = 1'b0;
  always @(negedge clk) begin
    if (ready_hold == 0) begin
      ready_level = ($urandom_range(0, 3) != 0);
      if (!ready_level) ready_hold = $urandom_range(1, 24);
      else if ($urandom_range(0, 9) == 0) ready_hold = $urandom_range(150, 400);
      else ready_hold = $urandom_range(1, 40);
    end else begin
      ready_hold--;
    end
    m_tready <= ready_level;
  end

  // --------------------------------------------------------------------------
  // Watchdog: end the run when no transaction moves for too long
  // --------------------------------------------------------------------------
  initial begin
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("Test completed with failures");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Every request on an empty table misses
  task automatic test_empty_table();
    send_keyed(mlt_pkg::OP_LOOKUP, '0);
    send_keyed(mlt_pkg::OP_DELETE, '1);
    send_keyed(mlt_pkg::OP_LOOKUP, '1);
  endtask

  // Field extremes, update of a known address, delete hit and miss, clear
  task automatic test_basic_ops();
    send_request(mlt_pkg::OP_LEARN, '0, '0);
    send_request(mlt_pkg::OP_LEARN, '1, '1);
    send_keyed(mlt_pkg::OP_LOOKUP, '0);
    send_keyed(mlt_pkg::OP_LOOKUP, '1);
    send_request(mlt_pkg::OP_LEARN, '1, 6'h15);
    send_keyed(mlt_pkg::OP_LOOKUP, '1);
    send_request(mlt_pkg::OP_LEARN, 48'h5555_5555_5555, 6'h2A);
    send_request(mlt_pkg::OP_LEARN, 48'hAAAA_AAAA_AAAA, 6'h15);
    send_keyed(mlt_pkg::OP_LOOKUP, 48'h5555_5555_5555);
    send_keyed(mlt_pkg::OP_LOOKUP, 48'hAAAA_AAAA_AAAA);
    send_keyed(mlt_pkg::OP_DELETE, '0);
    send_keyed(mlt_pkg::OP_LOOKUP, '0);
    send_keyed(mlt_pkg::OP_DELETE, '0);
    // Reuse the freed slot with a port beyond any real port count
    send_request(mlt_pkg::OP_LEARN, 48'h0000_0000_0001, 6'd63);
    send_keyed(mlt_pkg::OP_LOOKUP, 48'h0000_0000_0001);
    send_keyed(mlt_pkg::OP_CLEAR, rand_mac());
    send_keyed(mlt_pkg::OP_LOOKUP, '1);
    send_keyed(mlt_pkg::OP_DELETE, 48'h5555_5555_5555);
    send_request(mlt_pkg::OP_LEARN, 48'hAAAA_AAAA_AAAA, 6'h07);
    send_keyed(mlt_pkg::OP_LOOKUP, 48'hAAAA_AAAA_AAAA);
  endtask

  // Fill every slot, get refused, free one slot and learn into it
  task automatic test_table_full();
    logic [mlt_pkg::MAC_W-1:0] filled[TABLE_ENTRIES];
    logic [mlt_pkg::MAC_W-1:0] extra;
    send_keyed(mlt_pkg::OP_CLEAR, '0);
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      filled[i] = {24'h02_00_5E, 16'($urandom), 8'(i)};
      send_request(mlt_pkg::OP_LEARN, filled[i], mlt_pkg::PORT_W'($urandom_range(0, 63)));
    end
    extra = {24'h02_00_5F, 24'($urandom)};
    send_request(mlt_pkg::OP_LEARN, extra, 6'd9);
    send_keyed(mlt_pkg::OP_LOOKUP, extra);
    // Update of a known address still works on a full table
    send_request(mlt_pkg::OP_LEARN, filled[TABLE_ENTRIES-1], 6'd33);
    send_keyed(mlt_pkg::OP_LOOKUP, filled[TABLE_ENTRIES-1]);
    send_keyed(mlt_pkg::OP_DELETE, filled[10]);
    send_request(mlt_pkg::OP_LEARN, extra, 6'd9);
    send_keyed(mlt_pkg::OP_LOOKUP, extra);
    send_request(mlt_pkg::OP_LEARN, filled[10], 6'd1);
    send_keyed(mlt_pkg::OP_LOOKUP, filled[20]);
  endtask

  // Segments of random traffic over an address pool: a small pool churns a
  // few entries, a large pool drives the table into full; clears are rare
  task automatic test_random_traffic(input int segments, input int per_segment);
    int                        span;
    int                        clear_pct;
    int                        learn_pct;
    int                        roll;
    mlt_pkg::opcode_t          op;
    logic [mlt_pkg::MAC_W-1:0] mac;
    mac_pool[0] = '0;
    mac_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) mac_pool[i] = rand_mac();
    for (int s = 0; s < segments; s++) begin
      span      = ($urandom_range(0, 1) != 0) ? 8 : POOL_SIZE;
      clear_pct = ($urandom_range(0, 2) == 0) ? 4 : 0;
      learn_pct = (span == POOL_SIZE) ? 50 : 35;
      for (int n = 0; n < per_segment; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < clear_pct) op = mlt_pkg::OP_CLEAR;
        else if (roll < clear_pct + learn_pct) op = mlt_pkg::OP_LEARN;
        else if (roll < 80) op = mlt_pkg::OP_LOOKUP;
        else op = mlt_pkg::OP_DELETE;
        // Mostly pool addresses so hits happen; the rest is noise
        if ($urandom_range(0, 99) < 85) mac = mac_pool[$urandom_range(0, span - 1)];
        else mac = rand_mac();
        send_request(op, mac, mlt_pkg::PORT_W'($urandom_range(0, 63)));
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      shadow_valid[i] = 1'b0;
      shadow_mac[i]   = '0;
      shadow_port[i]  = '0;
    end
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_table();
    test_basic_ops();
    test_table_full();
    test_random_traffic(13, 50);

    // Release the request stream and drain the outstanding results
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_responses.size() != 0) @(posedge clk);
    repeat (TABLE_ENTRIES + 8) @(posedge clk);

    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
